### rtl/sost_pkg.sv
// ----------------------------------------------------------------------------
// sost_pkg
// Shared constants and types for the self-organizing search table with the
// transposition heuristic.
// ----------------------------------------------------------------------------
package sost_pkg;

   localparam int DEPTH_DEFAULT = 32;
   localparam int DATA_W        = 32;
   localparam int POS_W         = 5;
   localparam int LEN_W         = 6;
   localparam int SCAN_CAP      = 32;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   localparam logic REG_LENGTH_IN_USE = 1'b0;

   typedef struct packed {
      logic capture;
      logic scan;
      logic wr_entry;
      logic wr_swap_hi;
      logic wr_swap_lo;
      logic load_rsp;
      logic rsp_found;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic last;
      logic lim_zero;
      logic hit_front;
      logic rsp_free;
   } status_type;

endpackage

### rtl/sost_ctrl.sv
// ----------------------------------------------------------------------------
// sost_ctrl
// Sequencer for write, scan, swap write-back and result hand-off.
// ----------------------------------------------------------------------------
module sost_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_operation,
   input  sost_pkg::status_type  status,
   output sost_pkg::cmd_type     cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_SCAN,
      ST_SWAP_HI,
      ST_SWAP_LO,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      found_ff, found_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      found_in = found_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (req_operation == sost_pkg::OP_SEARCH) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            cmd.wr_entry = 1'b1;
            found_in     = 1'b0;
            state_in     = ST_RESP;
         end
         ST_SCAN: begin
            if (status.lim_zero) begin
               found_in = 1'b0;
               state_in = ST_RESP;
            end else if (status.hit) begin
               found_in = 1'b1;
               if (status.hit_front) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_SWAP_HI;
               end
            end else if (status.last) begin
               found_in = 1'b0;
               state_in = ST_RESP;
            end else begin
               cmd.scan = 1'b1;
            end
         end
         ST_SWAP_HI: begin
            cmd.wr_swap_hi = 1'b1;
            state_in       = ST_SWAP_LO;
         end
         ST_SWAP_LO: begin
            cmd.wr_swap_lo = 1'b1;
            state_in       = ST_RESP;
         end
         ST_RESP: begin
            cmd.rsp_found = found_ff;
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         found_ff <= found_in;
      end
   end

endmodule

### rtl/sost_dpath.sv
// ----------------------------------------------------------------------------
// sost_dpath
// Entry memory, scan pipeline, swap write-back, result register and the
// length register.
// ----------------------------------------------------------------------------
module sost_dpath #(
   parameter int DEPTH = sost_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sost_pkg::cmd_type                   cmd,
   output sost_pkg::status_type                status,
   input  logic [sost_pkg::POS_W-1:0]          req_entry_index,
   input  logic signed [sost_pkg::DATA_W-1:0]  req_entry_value,
   input  logic signed [sost_pkg::DATA_W-1:0]  req_search_key,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_found,
   output logic [sost_pkg::POS_W-1:0]          rsp_position,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [sost_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [sost_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [sost_pkg::CSR_DATA_W-1:0]     prdata
);

   localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SCAN_LIM = (DEPTH < sost_pkg::SCAN_CAP) ? DEPTH : sost_pkg::SCAN_CAP;

   logic signed [sost_pkg::DATA_W-1:0] entries_ff [DEPTH];

   logic [sost_pkg::LEN_W-1:0]         length_ff;
   logic [sost_pkg::LEN_W-1:0]         lim_ff;
   logic [sost_pkg::LEN_W-1:0]         lim_in;
   logic [sost_pkg::POS_W-1:0]         idx_ff;
   logic signed [sost_pkg::DATA_W-1:0] val_ff;
   logic signed [sost_pkg::DATA_W-1:0] key_ff;
   logic [sost_pkg::LEN_W-1:0]         rd_cnt_ff;
   logic                               vld_ff;
   logic [sost_pkg::POS_W-1:0]         data_idx_ff;
   logic signed [sost_pkg::DATA_W-1:0] rd_data_ff;
   logic signed [sost_pkg::DATA_W-1:0] prev_ff;
   logic                               rsp_valid_ff;
   logic                               rsp_found_ff;
   logic [sost_pkg::POS_W-1:0]         rsp_position_ff;

   logic                               rd_go;
   logic                               idx_ok;
   logic                               wr_en;
   logic [AW-1:0]                      wr_addr;
   logic signed [sost_pkg::DATA_W-1:0] wr_data;
   logic                               csr_wr;

   // Length register.
   assign csr_wr = psel && penable && pwrite && (paddr[2] == sost_pkg::REG_LENGTH_IN_USE);

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
      end else if (csr_wr) begin
         length_ff <= pwdata[sost_pkg::LEN_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == sost_pkg::REG_LENGTH_IN_USE) begin
         prdata = sost_pkg::CSR_DATA_W'(length_ff);
      end
   end

   // Request capture.
   assign lim_in = (32'(length_ff) > SCAN_LIM) ? sost_pkg::LEN_W'(SCAN_LIM) : length_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         idx_ff <= req_entry_index;
         val_ff <= req_entry_value;
         key_ff <= req_search_key;
         lim_ff <= lim_in;
      end
   end

   // Scan pipeline: one read issued per cycle, compared in the following cycle.
   assign rd_go = cmd.scan && (rd_cnt_ff < lim_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_cnt_ff <= '0;
         vld_ff    <= 1'b0;
      end else if (cmd.capture) begin
         rd_cnt_ff <= '0;
         vld_ff    <= 1'b0;
      end else if (cmd.scan) begin
         vld_ff <= rd_go;
         if (rd_go) begin
            rd_cnt_ff <= rd_cnt_ff + sost_pkg::LEN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan) begin
         if (vld_ff) begin
            prev_ff <= rd_data_ff;
         end
         if (rd_go) begin
            rd_data_ff  <= entries_ff[AW'(rd_cnt_ff)];
            data_idx_ff <= sost_pkg::POS_W'(rd_cnt_ff);
         end
      end
   end

   // Memory write port: plain write or one half of the swap.
   assign idx_ok = (32'(idx_ff) < 32'(DEPTH));

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = AW'(idx_ff);
      wr_data = val_ff;
      if (cmd.wr_entry && idx_ok) begin
         wr_en = 1'b1;
      end else if (cmd.wr_swap_hi) begin
         wr_en   = 1'b1;
         wr_addr = AW'(data_idx_ff);
         wr_data = prev_ff;
      end else if (cmd.wr_swap_lo) begin
         wr_en   = 1'b1;
         wr_addr = AW'(data_idx_ff - sost_pkg::POS_W'(1));
         wr_data = key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_addr] <= wr_data;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_found_ff    <= cmd.rsp_found;
         rsp_position_ff <= cmd.rsp_found ? data_idx_ff : '0;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;

   assign status.hit       = vld_ff && (rd_data_ff == key_ff);
   assign status.last      = vld_ff &&
                             ((sost_pkg::LEN_W'(data_idx_ff) + sost_pkg::LEN_W'(1)) == lim_ff);
   assign status.lim_zero  = (lim_ff == '0);
   assign status.hit_front = (data_idx_ff == '0);
   assign status.rsp_free  = !rsp_valid_ff || rsp_ready;

   a_swap_lo_not_front: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_swap_lo |-> (data_idx_ff != '0))
      else $error("Swap write-back below the front of the table.");

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.wr_entry, cmd.wr_swap_hi, cmd.wr_swap_lo}))
      else $error("More than one memory write requested in a cycle.");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("Result register loaded while a transaction is still pending.");

   a_swap_order: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_swap_hi |=> cmd.wr_swap_lo)
      else $error("Swap write-back left half done.");

endmodule

### rtl/self_organizing_search_transpose.sv
// ----------------------------------------------------------------------------
// self_organizing_search_transpose
// Search table with the transposition heuristic: top level.
// ----------------------------------------------------------------------------
// A request transaction on the req_ channel either writes req_entry_value at
// req_entry_index (operation 0) or searches the live entries for
// req_search_key (operation 1). Every request yields exactly one response
// transaction on the rsp_ channel: rsp_found and rsp_position report a hit
// and the index where the key stood before it was swapped with its
// predecessor. Writes and misses answer with zeros.
// The csr_ port holds length_in_use at byte address 0; the user is to write
// it only while the block is idle, and the block itself does not enforce
// this. The scan covers min(length_in_use, 32, DEPTH) entries.
// A search reads the entry memory one entry per cycle. The next request is
// accepted the cycle after the response is loaded, while that response may
// still wait for rsp_ready. When the receiver stalls, the block finishes at
// most one further transaction, holds its result and accepts nothing more.
// Reset clears the length register and the control state; entries read
// before they are written return undefined data.
// ----------------------------------------------------------------------------
module self_organizing_search_transpose #(
   parameter int DEPTH = sost_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_operation,
   input  logic [sost_pkg::POS_W-1:0]          req_entry_index,
   input  logic signed [sost_pkg::DATA_W-1:0]  req_entry_value,
   input  logic signed [sost_pkg::DATA_W-1:0]  req_search_key,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_found,
   output logic [sost_pkg::POS_W-1:0]          rsp_position,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sost_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [sost_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [sost_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   sost_pkg::cmd_type    cmd;
   sost_pkg::status_type status;

   assign csr_pready = 1'b1;

   sost_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .status        (status),
      .cmd           (cmd)
   );

   sost_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .req_search_key  (req_search_key),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_found       (rsp_found),
      .rsp_position    (rsp_position),
      .psel            (csr_psel),
      .penable         (csr_penable),
      .pwrite          (csr_pwrite),
      .paddr           (csr_paddr),
      .pwdata          (csr_pwdata),
      .prdata          (csr_prdata)
   );

endmodule
